FILE: sv/stli_pkg.sv
// Shared types and constants for the sorted table linear interpolator.
// No dependencies; used by every module of the block but stli_ram.
package stli_pkg;

    localparam int unsigned DEFAULT_DEPTH = 16;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_OUTSIDE  = 2'd2,
        ST_RESERVED = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic scan_rd;    // issue table read at scan index
        logic scan_eval;  // evaluate read data
        logic shift;      // one shift move step
        logic put;        // write new point
        logic mul_start;
        logic div_start;
        logic finish;     // build result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic shift_done;
        logic mul_done;
        logic div_done;
    } dp_stat_t;

endpackage

FILE: sv/stli_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module stli_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: sv/stli_datapath.sv
// Datapath: point memories, scan, shift mover, multiplier and divider.
// Depends on stli_pkg and stli_ram.
module stli_datapath #(
    parameter int unsigned DEPTH = stli_pkg::DEFAULT_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  stli_pkg::dp_cmd_t      cmd,
    output stli_pkg::dp_stat_t     stat,
    input  logic [1:0]             action,
    input  logic [31:0]            key_x,
    input  logic [31:0]            value_y,
    input  logic                   extrapolate_enable,
    output logic [31:0]            result_x,
    output logic [31:0]            result_y,
    output logic [1:0]             status,
    output logic [$clog2(DEPTH+1)-1:0] point_count,
    output logic                   need_shift,
    output logic                   need_put,
    output logic                   need_div
);
    import stli_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0] n_reg;
    logic [1:0]    act_reg;
    logic [31:0]   kx_reg;
    logic [31:0]   ky_reg;
    logic [CW-1:0] idx_reg;   // scan index
    logic [CW-1:0] rdi_reg;   // index of data arriving
    logic          found_reg;
    logic [CW-1:0] fidx_reg;  // matching index
    logic          gt_reg;
    logic [CW-1:0] pos_reg;   // first index with x > key
    logic signed [31:0] lox_reg, loy_reg, hix_reg, hiy_reg; // lower/upper neighbors
    logic signed [31:0] p0x_reg, p0y_reg, p1x_reg, p1y_reg; // first two
    logic signed [31:0] pax_reg, pay_reg, pbx_reg, pby_reg; // last two
    logic [CW-1:0] mv_reg;    // shift cursor
    logic          mvph_reg;  // 0 read, 1 write

    logic [31:0] x_rd, y_rd;
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0] wx_data, wy_data;

    stli_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_xs (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wx_data),
        .rd_addr(rd_addr), .rd_data(x_rd));
    stli_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ys (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wy_data),
        .rd_addr(rd_addr), .rd_data(y_rd));

    // shift direction: insert moves up from top, remove moves down
    logic is_ins;
    assign is_ins = (act_reg == ACT_INSERT);

    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        if (cmd.shift)
        begin
            rd_addr = is_ins ? AW'(mv_reg - CW'(1)) : AW'(mv_reg + CW'(1));
        end
        wr_en   = 1'b0;
        wr_addr = AW'(mv_reg);
        wx_data = x_rd;
        wy_data = y_rd;
        if (cmd.shift && mvph_reg)
        begin
            wr_en = 1'b1;
        end
        if (cmd.put)
        begin
            wr_en = 1'b1;
            wr_addr = found_reg ? AW'(fidx_reg) : AW'(pos_reg);
            wx_data = kx_reg;
            wy_data = ky_reg;
        end
    end

    // lower exists when the first point is <= key
    logic lo_any;
    assign lo_any = !gt_reg || (pos_reg != '0);

    // table status decisions
    logic full;
    assign full = (n_reg == CW'(DEPTH));
    always_comb
    begin
        need_put   = 1'b0;
        need_shift = 1'b0;
        need_div   = 1'b0;
        case (act_reg)
            ACT_INSERT:
            begin
                need_put   = found_reg || !full;
                need_shift = !found_reg && !full && (pos_reg != n_reg);
            end
            ACT_REMOVE:
            begin
                need_shift = found_reg && (fidx_reg + CW'(1) < n_reg);
            end
            ACT_QUERY:
            begin
                need_div = (n_reg >= CW'(2)) && !found_reg &&
                           (extrapolate_enable || (gt_reg && lo_any));
            end
            default: ;
        endcase
    end

    assign stat.scan_last  = (idx_reg + CW'(1) >= n_reg);
    assign stat.shift_done = is_ins ? (mv_reg == pos_reg + CW'(1) && mvph_reg)
                                    : (mv_reg + CW'(2) == n_reg && mvph_reg);

    // scan and shift registers
    logic signed [31:0] xs;
    assign xs = $signed(x_rd);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= '0;
            idx_reg   <= '0;
            mvph_reg  <= 1'b0;
            found_reg <= 1'b0;
            gt_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                act_reg   <= action;
                kx_reg    <= key_x;
                ky_reg    <= value_y;
                idx_reg   <= '0;
                found_reg <= 1'b0;
                gt_reg    <= 1'b0;
                pos_reg   <= n_reg;
                fidx_reg  <= '0;
                mvph_reg  <= 1'b0;
            end
            if (cmd.scan_rd)
            begin
                rdi_reg <= idx_reg;
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.scan_eval)
            begin
                if (xs == $signed(kx_reg))
                begin
                    found_reg <= 1'b1;
                    fidx_reg  <= rdi_reg;
                end
                if (xs <= $signed(kx_reg))
                begin
                    lox_reg <= xs;
                    loy_reg <= $signed(y_rd);
                end
                else if (!gt_reg)
                begin
                    gt_reg  <= 1'b1;
                    pos_reg <= rdi_reg;
                    hix_reg <= xs;
                    hiy_reg <= $signed(y_rd);
                end
                if (rdi_reg == '0)
                begin
                    p0x_reg <= xs;
                    p0y_reg <= $signed(y_rd);
                end
                if (rdi_reg == CW'(1))
                begin
                    p1x_reg <= xs;
                    p1y_reg <= $signed(y_rd);
                end
                pax_reg <= pbx_reg;
                pay_reg <= pby_reg;
                pbx_reg <= xs;
                pby_reg <= $signed(y_rd);
                // cursor start for a shift
                mv_reg <= is_ins ? n_reg : fidx_reg;
            end
            if (cmd.shift)
            begin
                mvph_reg <= !mvph_reg;
                if (mvph_reg)
                begin
                    mv_reg <= is_ins ? mv_reg - CW'(1) : mv_reg + CW'(1);
                end
            end
            if (cmd.finish)
            begin
                if (act_reg == ACT_INSERT && !found_reg && !full)
                begin
                    n_reg <= n_reg + CW'(1);
                end
                if (act_reg == ACT_REMOVE && found_reg)
                begin
                    n_reg <= n_reg - CW'(1);
                end
            end
        end
    end

    // remove cursor: the eval after the match copies the registered match
    // index; a match at the last entry needs no shift at all

    // segment selection and operands
    logic signed [31:0] sax, say, sbx, sby;
    always_comb
    begin
        if (gt_reg && !lo_any)
        begin
            sax = p0x_reg; say = p0y_reg; sbx = p1x_reg; sby = p1y_reg;
        end
        else if (!gt_reg)
        begin
            sax = pax_reg; say = pay_reg; sbx = pbx_reg; sby = pby_reg;
        end
        else
        begin
            sax = lox_reg; say = loy_reg; sbx = hix_reg; sby = hiy_reg;
        end
    end

    logic signed [32:0] dxq, dy, dx;
    assign dxq = 33'(signed'(kx_reg)) - 33'(sax);
    assign dy  = 33'(sby) - 33'(say);
    assign dx  = 33'(sbx) - 33'(sax);

    // multiplier: 33x33 magnitude as four 17x17 partials, one per cycle
    logic [32:0] ma_reg, mb_reg, d_reg;
    logic        neg_reg;
    logic signed [31:0] y0_reg;
    logic [65:0] prod_reg;
    logic [2:0]  mstep_reg;
    logic        mbusy_reg;
    logic [16:0] pa, pb;
    logic [33:0] pp;
    always_comb
    begin
        pa = mstep_reg[1] ? {1'b0, ma_reg[32:17]} : ma_reg[16:0];
        pb = mstep_reg[0] ? {1'b0, mb_reg[32:17]} : mb_reg[16:0];
        pp = 34'(pa) * 34'(pb);
    end
    logic [5:0] sh;
    assign sh = 6'(17 * (32'(mstep_reg[1]) + 32'(mstep_reg[0])));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mstep_reg <= '0;
        end
        else if (cmd.mul_start)
        begin
            ma_reg    <= dxq[32] ? 33'(-dxq) : 33'(dxq);
            mb_reg    <= dy[32] ? 33'(-dy) : 33'(dy);
            d_reg     <= 33'(dx);
            neg_reg   <= dxq[32] ^ dy[32];
            y0_reg    <= say;
            prod_reg  <= '0;
            mstep_reg <= '0;
            mbusy_reg <= 1'b1;
        end
        else if (mbusy_reg)
        begin
            prod_reg  <= prod_reg + (66'(pp) << sh);
            mstep_reg <= mstep_reg + 3'd1;
            if (mstep_reg == 3'd3)
            begin
                mbusy_reg <= 1'b0;
            end
        end
    end
    assign stat.mul_done = !mbusy_reg && (mstep_reg == 3'd4);

    // restoring divider, one quotient bit a cycle, quotient clamped
    localparam logic [41:0] QCAP = 42'h100_0000_0000;
    logic [65:0] dvd_reg;
    logic [33:0] rem_reg;
    logic [41:0] q_reg;
    logic [6:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [33:0] rtry;
    logic [41:0] qn;
    assign rtry = {rem_reg[32:0], dvd_reg[65]};
    always_comb
    begin
        qn = {q_reg[40:0], 1'b0};
        if (rtry >= 34'(d_reg))
        begin
            qn[0] = 1'b1;
        end
        if (qn > QCAP)
        begin
            qn = QCAP;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dvd_reg   <= prod_reg;
            rem_reg   <= '0;
            q_reg     <= '0;
            dcnt_reg  <= 7'd66;
            dbusy_reg <= 1'b1;
        end
        else if (dbusy_reg)
        begin
            dvd_reg <= {dvd_reg[64:0], 1'b0};
            rem_reg <= (rtry >= 34'(d_reg)) ? rtry - 34'(d_reg) : rtry;
            q_reg   <= qn;
            dcnt_reg <= dcnt_reg - 7'd1;
            if (dcnt_reg == 7'd1)
            begin
                dbusy_reg <= 1'b0;
            end
        end
    end
    assign stat.div_done = !dbusy_reg && (dcnt_reg == '0);

    // saturated result
    logic signed [43:0] sum;
    assign sum = neg_reg ? 44'(y0_reg) - 44'(signed'({1'b0, q_reg}))
                         : 44'(y0_reg) + 44'(signed'({1'b0, q_reg}));

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_x <= kx_reg;
            result_y <= '0;
            status   <= ST_OK;
            if (act_reg == ACT_INSERT && !found_reg && full)
            begin
                status <= ST_FULL;
            end
            if (act_reg == ACT_QUERY)
            begin
                if (n_reg == CW'(1))
                begin
                    result_x <= p0x_reg;
                    result_y <= p0y_reg;
                end
                else if (n_reg >= CW'(2))
                begin
                    if (found_reg)
                    begin
                        result_y <= (fidx_reg == '0) ? p0y_reg : loy_reg;
                    end
                    else if (!need_div)
                    begin
                        status <= ST_OUTSIDE;
                    end
                    else if (sum > 44'sd2147483647)
                    begin
                        result_y <= 32'h7FFF_FFFF;
                    end
                    else if (sum < -44'sd2147483648)
                    begin
                        result_y <= 32'h8000_0000;
                    end
                    else
                    begin
                        result_y <= sum[31:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count <= '0;
        end
        else if (cmd.finish)
        begin
            point_count <= n_reg;
            if (act_reg == ACT_INSERT && !found_reg && !full)
            begin
                point_count <= n_reg + CW'(1);
            end
            if (act_reg == ACT_REMOVE && found_reg)
            begin
                point_count <= n_reg - CW'(1);
            end
        end
    end
endmodule

FILE: sv/stli_ctrl.sv
// Controller state machine sequencing scan, shift, write, multiply, divide.
// Depends on stli_pkg.
module stli_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic               has_points,
    input  logic               need_shift,
    input  logic               need_put,
    input  logic               need_div,
    input  stli_pkg::dp_stat_t stat,
    output stli_pkg::dp_cmd_t  cmd
);
    import stli_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_EVAL  = 10'b0000000100,
        S_DEC   = 10'b0000001000,
        S_SHIFT = 10'b0000010000,
        S_PUT   = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg;
    logic   first_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    // empty table: no scan, straight to the decision
                    state_next = has_points ? S_RD : S_DEC;
                end
            end
            S_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.scan_eval = 1'b1;
                state_next = last_reg ? S_DEC : S_RD;
            end
            S_DEC:
            begin
                if (need_shift)
                begin
                    state_next = S_SHIFT;
                end
                else if (need_put)
                begin
                    state_next = S_PUT;
                end
                else if (need_div)
                begin
                    cmd.mul_start = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = need_put ? S_PUT : S_FIN;
                end
            end
            S_PUT:
            begin
                cmd.put = 1'b1;
                state_next = S_FIN;
            end
            S_MUL:
            begin
                if (stat.mul_done && !first_reg)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done && !first_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= cmd.mul_start || cmd.div_start;
            if (cmd.scan_rd)
            begin
                last_reg <= stat.scan_last;
            end
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
endmodule

FILE: sv/sorted_table_linear_interpolator_core.sv
// Top level of the sorted breakpoint table with linear interpolation.
// Depends on stli_pkg, stli_ctrl, stli_datapath, stli_ram.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid/in_stall   | action, key_x, value_y
//  out     | out_valid/out_stall | result_x, result_y, status, point_count
//  cfg     | cfg_valid/cfg_ready | cfg_data (extrapolate_enable)
//
// One item at a time. The scan reads each stored point with a read state and
// an evaluate state, a shift move reads then writes each entry through the single
// RAM read port, and an interpolating query adds a multiply and a divide;
// the block takes a new item once its result is transferred.
// Reset clears count, state and sets extrapolation on; RAMs need none.
module sorted_table_linear_interpolator_core #(
    parameter int unsigned TABLE_DEPTH = stli_pkg::DEFAULT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] key_x,
    input  logic [31:0] value_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_x,
    output logic [31:0] result_y,
    output logic [1:0]  status,
    output logic [4:0]  point_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import stli_pkg::*;

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     need_shift, need_put, need_div;
    logic     extrap_reg;
    logic [CW-1:0] cnt;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extrap_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            extrap_reg <= cfg_data;
        end
    end

    stli_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .has_points(cnt != '0),
        .need_shift(need_shift), .need_put(need_put), .need_div(need_div),
        .stat(stat), .cmd(cmd));

    stli_datapath #(.DEPTH(TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .action(action), .key_x(key_x), .value_y(value_y),
        .extrapolate_enable(extrap_reg),
        .result_x(result_x), .result_y(result_y), .status(status),
        .point_count(cnt),
        .need_shift(need_shift), .need_put(need_put), .need_div(need_div));

    assign point_count = 5'(cnt);

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_y))
        else $error("result changed while stalled");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt) <= TABLE_DEPTH)
        else $error("point count beyond depth");
`endif
endmodule

FILE: dv/stli_checker.sv
// Checker for the sorted table interpolator: tracks input and output transfers,
// predicts each result from its own table copy and compares. Depends on stli_pkg.
module stli_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] key_x,
    input  logic [31:0] value_y,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] result_x,
    input  logic [31:0] result_y,
    input  logic [1:0]  status,
    input  logic [4:0]  point_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          fail_count,
    output int          pending
);
    import stli_pkg::*;

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        status_t     st;
        logic [4:0]  cnt;
    } answer_t;

    logic signed [31:0] tbl_x [DEPTH];
    logic signed [31:0] tbl_y [DEPTH];
    int unsigned        npts;
    logic               extrap;
    answer_t            answers [$];

    // y0 + trunc(dxq*dy/dx), quotient magnitude capped at 2^40, then saturated
    function automatic logic signed [31:0] lerp(longint y0, longint dxq, longint dy,
                                                longint dx);
        logic [127:0] prod;
        logic [127:0] q;
        longint       qv;
        longint       r;
        logic         neg;
        neg  = (dxq < 0) != (dy < 0);
        prod = 128'((dxq < 0) ? -dxq : dxq) * 128'((dy < 0) ? -dy : dy);
        q    = prod / 128'(dx);
        qv   = (q > 128'(64'd1 << 40)) ? (64'sd1 <<< 40) : longint'(q);
        r    = neg ? y0 - qv : y0 + qv;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic answer_t predict(action_t act, logic signed [31:0] x,
                                        logic signed [31:0] y);
        answer_t a;
        int      pos;
        int      lo;
        int      ia;
        int      ib;
        bit      hit;
        a.rx = x;
        a.ry = '0;
        a.st = ST_OK;
        hit  = 0;
        case (act)
            ACT_INSERT: begin
                for (int i = 0; i < npts; i++)
                    if (!hit && tbl_x[i] == x) begin
                        tbl_y[i] = y;
                        hit = 1;
                    end
                if (!hit) begin
                    if (npts >= DEPTH)
                        a.st = ST_FULL;
                    else begin
                        pos = npts;
                        for (int i = npts - 1; i >= 0; i--)
                            if (tbl_x[i] > x)
                                pos = i;
                        for (int i = npts; i > pos; i--) begin
                            tbl_x[i] = tbl_x[i-1];
                            tbl_y[i] = tbl_y[i-1];
                        end
                        tbl_x[pos] = x;
                        tbl_y[pos] = y;
                        npts++;
                    end
                end
            end
            ACT_REMOVE: begin
                pos = -1;
                for (int i = 0; i < npts; i++)
                    if (pos < 0 && tbl_x[i] == x)
                        pos = i;
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < npts; i++) begin
                        tbl_x[i] = tbl_x[i+1];
                        tbl_y[i] = tbl_y[i+1];
                    end
                    npts--;
                end
            end
            ACT_QUERY: begin
                if (npts == 1) begin
                    a.rx = tbl_x[0];
                    a.ry = tbl_y[0];
                end else if (npts >= 2) begin
                    lo = -1;
                    for (int i = 0; i < npts; i++)
                        if (tbl_x[i] <= x)
                            lo = i;
                    if (lo >= 0 && tbl_x[lo] == x)
                        a.ry = tbl_y[lo];
                    else if ((lo < 0 || lo == npts - 1) && !extrap)
                        a.st = ST_OUTSIDE;
                    else begin
                        ia = (lo < 0) ? 0 : (lo == npts - 1) ? npts - 2 : lo;
                        ib = ia + 1;
                        a.ry = lerp(tbl_y[ia], longint'(x) - tbl_x[ia],
                                    longint'(tbl_y[ib]) - tbl_y[ia],
                                    longint'(tbl_x[ib]) - tbl_x[ia]);
                    end
                end
            end
            default: ;
        endcase
        a.cnt = 5'(npts);
        return a;
    endfunction

    // monitor all three channels
    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n) begin
            npts       <= 0;
            extrap     <= 1'b1;
            fail_count <= 0;
            pending    <= 0;
            answers.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                extrap = cfg_data;
            if (in_valid && !in_stall)
                answers.insert(answers.size(),
                               predict(action_t'(action), key_x, value_y));
            if (out_valid && !out_stall) begin
                got = '{result_x, result_y, status_t'(status), point_count};
                if (answers.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = answers.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected x=%h y=%h st=%0d n=%0d",
                                 $time, want.rx, want.ry, want.st, want.cnt);
                        $display("%0t:          actual   x=%h y=%h st=%0d n=%0d",
                                 $time, got.rx, got.ry, got.st, got.cnt);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= answers.size();
        end
    end

endmodule

FILE: dv/tb.sv
// Testbench top for sorted_table_linear_interpolator_core: drives table edits,
// queries and the extrapolation register. Depends on stli_pkg and stli_checker.
module tb;
    import stli_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG = 200000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  action = ACT_NONE;
    logic [31:0] key_x = '0;
    logic [31:0] value_y = '0;
    logic        out_valid;
    logic        out_stall = 1;
    logic [31:0] result_x;
    logic [31:0] result_y;
    logic [1:0]  status;
    logic [4:0]  point_count;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_data = 0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          stall_left = 0;
    logic [31:0] keys [$];

    always #10 clk = ~clk;

    sorted_table_linear_interpolator_core #(.TABLE_DEPTH(DEPTH)) DUT (.*);

    stli_checker #(.DEPTH(DEPTH)) u_checker (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stall pattern: bursts of random length
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0)
                stall_left <= gap_len();
        end
    end

    // watchdog: cycles with no transfer at all
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("** sorted_table_linear_interpolator_core: FAILED **");
            $finish;
        end
    end

    // valid stays high back to back; it drops only for a gap or a drain
    task automatic send(action_t act, logic [31:0] x, logic [31:0] y);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        key_x    <= x;
        value_y  <= y;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_extrap(logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // key choice: reuse stored keys often so hits, replaces and removes occur
    function automatic logic [31:0] pick_key(int spread);
        if (keys.size() != 0 && $urandom_range(0, 2) == 0)
            return keys[$urandom_range(0, keys.size() - 1)];
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom())};
            default: return 32'($signed(32'($urandom_range(0, spread))) - spread / 2) << 16;
        endcase
    endfunction

    task automatic random_item(int spread);
        int          r;
        logic [31:0] k;
        r = $urandom_range(0, 99);
        k = pick_key(spread);
        if (r < 40) begin
            send(ACT_INSERT, k, $urandom_range(0, 3) == 0 ?
                 {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())} : $urandom());
            keys.insert(keys.size(), k);
            if (keys.size() > 40)
                void'(keys.pop_front());
        end else if (r < 55)
            send(ACT_REMOVE, k, $urandom());
        else if (r < 98)
            send(ACT_QUERY, k, $urandom());
        else
            send(ACT_NONE, k, $urandom());
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, single point, exact hit, extremes, full table
        send(ACT_QUERY, 32'h0001_0000, 32'h0);
        send(ACT_REMOVE, 32'h5, 32'h0);
        send(ACT_INSERT, 32'h0002_0000, 32'h0005_0000);
        send(ACT_QUERY, 32'hffff_0000, 32'h0);
        send(ACT_INSERT, 32'h0004_0000, 32'h0009_0000);
        send(ACT_QUERY, 32'h0003_0000, 32'h0);
        send(ACT_QUERY, 32'h0004_0000, 32'h0);
        send(ACT_INSERT, 32'h0004_0000, 32'hffff_0000);
        send(ACT_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send(ACT_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send(ACT_QUERY, 32'h7fff_fffe, 32'h0);
        send(ACT_QUERY, 32'h8000_0001, 32'h0);
        send(ACT_NONE, 32'hffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < 13; i++)
            send(ACT_INSERT, 32'((i + 10) << 16), 32'(i * 3));
        send(ACT_INSERT, 32'h0100_0000, 32'h1);
        send(ACT_REMOVE, 32'h8000_0000, 32'h0);
        send(ACT_REMOVE, 32'h7fff_ffff, 32'h0);
        send(ACT_QUERY, 32'h7000_0000, 32'h0);
        drain();

        write_extrap(1'b0);
        send(ACT_QUERY, 32'h7000_0000, 32'h0);
        send(ACT_QUERY, 32'h9000_0000, 32'h0);
        drain();
        write_extrap(1'b1);

        // random phases across both register settings
        for (int ph = 0; ph < 8; ph++) begin
            for (int i = 0; i < 250; i++)
                random_item(ph[0] ? 64 : 4000);
            drain();
            if (ph != 7)
                write_extrap($urandom_range(0, 1));
        end

        drain();
        if (fail_count == 0)
            $display("** sorted_table_linear_interpolator_core: PASSED **");
        else
            $display("** sorted_table_linear_interpolator_core: FAILED **");
        $finish;
    end

endmodule
